>>> src/dcbf_pkg.sv
package dcbf_pkg;

  localparam int unsigned DataW   = 8;
  localparam int unsigned AlphaW  = 16;
  localparam int unsigned SampleW = 16;
  localparam int unsigned StateW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [AlphaW-1:0] AlphaReset = 16'd65489;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  typedef enum logic {
    KIND_READ   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_ALPHA  = 2'd1
  } cfg_idx_e;

endpackage

>>> src/dcbf_filter.sv
module dcbf_filter import dcbf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tick_i,
  input  logic [DataW-1:0]          level_i,
  input  logic [AlphaW-1:0]         alpha_i,
  output logic signed [SampleW-1:0] sample_o
);

  logic signed [StateW-1:0] filter_q, filter_d;
  logic        [DataW-1:0]  prev_q;

  logic signed [DataW:0]    diff;
  logic signed [23:0]       delta;
  logic signed [StateW:0]   sum;
  logic signed [AlphaW:0]   alpha_s;
  logic signed [49:0]       prod;
  logic signed [49:0]       rnd;
  logic signed [33:0]       y_full;
  logic signed [StateW-1:0] y_sat;
  logic                     idle;
  logic signed [StateW:0]   s_rnd;
  logic signed [24:0]       s_full;

  assign diff    = $signed({1'b0, level_i}) - $signed({1'b0, prev_q});
  assign delta   = {diff, 15'd0};
  assign sum     = {filter_q[StateW-1], filter_q} + {{(StateW+1-24){delta[23]}}, delta};
  assign alpha_s = $signed({1'b0, alpha_i});
  assign prod    = sum * alpha_s;
  assign rnd     = prod + 50'sd32768;
  assign y_full  = rnd[49:16];

  always_comb begin
    if ((y_full[33:31] == 3'b000) || (y_full[33:31] == 3'b111)) begin
      y_sat = y_full[31:0];
    end else if (y_full[33]) begin
      y_sat = {1'b1, {(StateW-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(StateW-1){1'b1}}};
    end
  end

  assign idle     = (level_i == prev_q) && (y_sat > -32'sd128) && (y_sat < 32'sd128);
  assign filter_d = idle ? '0 : y_sat;

  // round half up to the integer part, then saturate
  assign s_rnd  = {filter_d[StateW-1], filter_d} + 33'sd128;
  assign s_full = s_rnd[StateW:8];

  always_comb begin
    if ((s_full[24:15] == 10'h000) || (s_full[24:15] == 10'h3ff)) begin
      sample_o = s_full[SampleW-1:0];
    end else if (s_full[24]) begin
      sample_o = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      sample_o = {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q <= '0;
      prev_q   <= '0;
    end else if (tick_i) begin
      filter_q <= filter_d;
      prev_q   <= level_i;
    end
  end

endmodule

>>> src/dac_dc_blocking_filter.sv
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | mode_i, data_i
// out     | out | out_valid/out_ready | result_kind_o, read_data_o, sample_o
// cfg     | in  | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
//
// One item per cycle unless a stalled output holds stage s1; an accepted item is
// registered in s1, and its result is registered in the result register when it leaves s1.
// The filter update is a single combinational 33x17 multiply with round and saturate.
// Reset clears the DAC level, filter state and valid bits and sets the config registers to their reset values.
// A stalled output only holds back items that give a result; writes still drain.
module dac_dc_blocking_filter import dcbf_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                mode_i,
  input  logic [DataW-1:0]          data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      result_kind_o,
  output logic [DataW-1:0]          read_data_o,
  output logic signed [SampleW-1:0] sample_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgW-1:0]           cfg_data_i
);

  logic                      enable_q;
  logic [AlphaW-1:0]         alpha_q;
  logic [DataW-1:0]          dac_level_q;

  logic                      s1_valid_q;
  logic [1:0]                s1_mode_q;
  logic [DataW-1:0]          s1_data_q;

  logic                      out_valid_q;
  kind_e                     out_kind_q;
  logic [DataW-1:0]          out_read_q;
  logic signed [SampleW-1:0] out_sample_q;

  logic                      has_result;
  logic                      s1_adv;
  logic                      tick;
  logic signed [SampleW-1:0] filt_sample;

  always_comb begin
    unique case (s1_mode_q)
      MODE_READ, MODE_TICK: has_result = 1'b1;
      default:              has_result = 1'b0;
    endcase
  end

  assign s1_adv      = s1_valid_q && (!has_result || !out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign tick        = s1_adv && (s1_mode_q == MODE_TICK);
  assign cfg_ready_o = 1'b1;

  dcbf_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .level_i  (dac_level_q),
    .alpha_i  (alpha_q),
    .sample_o (filt_sample)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      alpha_q  <= AlphaReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE: enable_q <= cfg_data_i[0];
        CFG_ALPHA:  alpha_q  <= cfg_data_i[AlphaW-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dac_level_q <= '0;
    end else if (s1_adv && (s1_mode_q == MODE_WRITE) && enable_q) begin
      dac_level_q <= s1_data_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_mode_q  <= '0;
      s1_data_q  <= '0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
      s1_mode_q  <= mode_i;
      s1_data_q  <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && has_result) begin
      if (s1_mode_q == MODE_TICK) begin
        out_kind_q   <= KIND_SAMPLE;
        out_read_q   <= '0;
        out_sample_q <= filt_sample;
      end else begin
        out_kind_q   <= KIND_READ;
        out_read_q   <= dac_level_q;
        out_sample_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign read_data_o   = out_read_q;
  assign sample_o      = out_sample_q;

`ifndef SYNTH
  a_write_stores : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_mode_q == MODE_WRITE) && enable_q |=> dac_level_q == $past(s1_data_q))
    else $error("enabled write did not store the level");

  a_write_ignored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && (s1_mode_q == MODE_WRITE) && !enable_q |=> $stable(dac_level_q))
    else $error("disabled write changed the level");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && has_result && out_valid_q && !out_ready_i |-> !s1_adv)
    else $error("result register overwritten while stalled");

  a_tick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> out_valid_q && (out_kind_q == KIND_SAMPLE) && (out_read_q == '0))
    else $error("tick did not produce a sample result");
`endif

endmodule

>>> tb/tb_dac_dc_blocking_filter.sv
module tb_dac_dc_blocking_filter;
  import dcbf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]         ModeUnused   = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareB = 2'd3;
  localparam int                 ItemsPerPass = 215;
  localparam int                 NumPasses    = 8;
  localparam int                 LongHold     = 300;
  localparam int                 StallLimit   = 4000;
  localparam int                 SettleCycles = 4;
  localparam longint             StateMax     = 64'sd2147483647;
  localparam longint             StateMin     = -64'sd2147483648;

  typedef struct packed {
    kind_e                     kind;
    logic [DataW-1:0]          rd;
    logic signed [SampleW-1:0] smp;
  } result_t;

  typedef struct packed {
    logic        is_reg;
    logic [1:0]  code;
    logic [15:0] val;
    logic        typed;
    result_t     res;
  } step_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [1:0]                mode_i;
  logic [DataW-1:0]          data_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      result_kind_o;
  logic [DataW-1:0]          read_data_o;
  logic signed [SampleW-1:0] sample_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [CfgW-1:0]           cfg_data_i;

  // shadow of the block state
  logic                      enable_q     = 1'b0;
  logic [AlphaW-1:0]         alpha_q      = AlphaReset;
  logic [DataW-1:0]          level_q      = '0;
  logic [DataW-1:0]          prev_level_q = '0;
  logic signed [StateW-1:0]  filt_q       = '0;

  result_t dac_results_q[$];
  step_t   steps[$];
  logic    use_typed = 1'b0;
  result_t typed_res = '0;
  int      errors = 0;
  int      stall_cycles = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  logic    hold_long = 1'b0;

  dac_dc_blocking_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .data_i        (data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .read_data_o   (read_data_o),
    .sample_o      (sample_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t filter_tick();
    longint  acc;
    longint  y;
    longint  s;
    result_t r;
    acc = longint'(filt_q) + (longint'(level_q) - longint'(prev_level_q)) * 32768;
    y = (acc * longint'(alpha_q) + 32768) >>> 16;
    if (y > StateMax) y = StateMax;
    if (y < StateMin) y = StateMin;
    // idle shortcut: steady level and |y| below one half
    if (level_q == prev_level_q && y > -128 && y < 128) y = 0;
    filt_q = 32'(y);
    prev_level_q = level_q;
    s = (y + 128) >>> 8;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    r.kind = KIND_SAMPLE;
    r.rd = '0;
    r.smp = 16'(s);
    return r;
  endfunction

  task automatic flag(string what, longint want, longint got);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  always @(posedge clk_i) begin : monitor
    result_t want;
    logic    moved;
    logic    has;
    if (rst_ni) begin
      moved = 1'b0;
      has = 1'b0;
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (dac_results_q.size() == 0) begin
          flag("unexpected result, kind", -1, result_kind_o);
        end else begin
          want = dac_results_q.pop_front();
          if (result_kind_o !== want.kind) flag("result_kind", want.kind, result_kind_o);
          if (read_data_o !== want.rd) flag("read_data", want.rd, read_data_o);
          if (sample_o !== want.smp) flag("sample", want.smp, sample_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        case (mode_i)
          MODE_WRITE: if (enable_q) level_q = data_i;
          MODE_READ: begin
            want = '{KIND_READ, level_q, '0};
            has = 1'b1;
          end
          MODE_TICK: begin
            want = filter_tick();
            has = 1'b1;
          end
          default: ;
        endcase
        if (has) dac_results_q.push_back(use_typed ? typed_res : want);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (cfg_index_i)
          CFG_ENABLE: enable_q = cfg_data_i[0];
          CFG_ALPHA:  alpha_q = cfg_data_i[AlphaW-1:0];
          default: ;
        endcase
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("Regression FAIL");
    $finish;
  end

  // output side backpressure
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_ready_i <= 1'b0;
        repeat (LongHold - 1) @(negedge clk_i);
        hold_long = 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic feed(logic [1:0] m, logic [7:0] d, logic typed, result_t res);
    use_typed = typed;
    typed_res = res;
    in_valid_i <= 1'b1;
    mode_i <= m;
    data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (dac_results_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  function automatic void tbl_item(logic [1:0] m, logic [7:0] d);
    steps.push_back('{1'b0, m, 16'(d), 1'b0, result_t'('0)});
  endfunction

  function automatic void tbl_read(logic [7:0] lvl);
    result_t r;
    r.kind = KIND_READ;
    r.rd = lvl;
    r.smp = '0;
    steps.push_back('{1'b0, MODE_READ, 16'h00C3, 1'b1, r});
  endfunction

  function automatic void tbl_zero_tick();
    result_t r;
    r.kind = KIND_SAMPLE;
    r.rd = '0;
    r.smp = '0;
    steps.push_back('{1'b0, MODE_TICK, 16'h003C, 1'b1, r});
  endfunction

  function automatic void tbl_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    steps.push_back('{1'b1, idx, val, 1'b0, result_t'('0)});
  endfunction

  initial begin
    int          p;
    int          n;
    int          r;
    logic        en;
    logic [15:0] alpha;
    logic [1:0]  m;
    logic [7:0]  d;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    mode_i = MODE_WRITE;
    data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_ENABLE;
    cfg_data_i = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    tbl_read(8'h00);
    tbl_zero_tick();
    tbl_item(MODE_WRITE, 8'hFF);
    tbl_read(8'h00);
    tbl_item(ModeUnused, 8'hA5);
    tbl_reg(CfgIdxSpareA, 16'hFFFF);
    tbl_reg(CfgIdxSpareB, 16'h1235);
    tbl_item(MODE_WRITE, 8'h3C);
    tbl_read(8'h00);
    tbl_reg(CFG_ENABLE, 16'h0001);
    tbl_item(MODE_WRITE, 8'hFF);
    tbl_read(8'hFF);
    tbl_item(MODE_TICK, 8'h00);
    tbl_item(MODE_TICK, 8'hFF);
    tbl_item(MODE_WRITE, 8'h00);
    tbl_read(8'h00);
    tbl_item(MODE_TICK, 8'h5A);
    tbl_reg(CFG_ALPHA, 16'h1000);
    tbl_item(MODE_WRITE, 8'h01);
    tbl_item(MODE_TICK, 8'h00);
    tbl_item(MODE_TICK, 8'h00);
    tbl_item(MODE_TICK, 8'h00);
    tbl_reg(CFG_ALPHA, 16'h0000);
    tbl_item(MODE_WRITE, 8'h80);
    tbl_zero_tick();
    tbl_item(MODE_WRITE, 8'h55);
    tbl_read(8'h55);
    tbl_reg(CFG_ALPHA, 16'hFFFF);
    tbl_item(MODE_TICK, 8'hFF);
    tbl_item(MODE_TICK, 8'h00);

    tx_idle_pct = 20;
    rx_idle_pct = 20;
    foreach (steps[i]) begin
      if (steps[i].is_reg) begin
        drain();
        write_reg(steps[i].code, steps[i].val);
        cfg_valid_i <= 1'b0;
      end else begin
        feed(steps[i].code, steps[i].val[7:0], steps[i].typed, steps[i].res);
      end
    end

    // random part, one alpha and enable setting per pass
    for (p = 0; p < NumPasses; p++) begin
      drain();
      case (p)
        0: alpha = AlphaReset;
        1: alpha = 16'hFFFF;
        3: alpha = 16'h0000;
        4: alpha = 16'h0001;
        5: alpha = 16'($urandom_range(0, 16384));
        6: alpha = 16'($urandom_range(32768, 65535));
        default: alpha = 16'($urandom);
      endcase
      en = (p != 2);
      write_reg(CFG_ALPHA, alpha);
      write_reg(CFG_ENABLE, {15'($urandom), en});
      cfg_valid_i <= 1'b0;
      tx_idle_pct = (p == 4 || p == NumPasses - 1) ? 0 : 15;
      rx_idle_pct = (p == 4 || p == NumPasses - 1) ? 0 : ((p == 3) ? 35 : 15);
      if (p == 1) hold_long = 1'b1;
      n = 0;
      while (n < ItemsPerPass) begin
        if ($urandom_range(0, 9) == 0) begin
          // steady level: a run of ticks lets the filter settle
          repeat ($urandom_range(5, 30)) begin
            feed(MODE_TICK, 8'($urandom), 1'b0, '0);
            n++;
          end
        end else begin
          r = $urandom_range(0, 99);
          m = (r < 30) ? MODE_WRITE : (r < 48) ? MODE_READ : (r < 95) ? MODE_TICK : ModeUnused;
          if ($urandom_range(0, 4) == 0) d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          else d = 8'($urandom);
          feed(m, d, 1'b0, '0);
          if (m != ModeUnused && !(m == MODE_WRITE && !en)) n++;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (dac_results_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
